// File: hdl/ptc_pkg.sv
package ptc_pkg;

	localparam int FIFO_DEPTH_DEF = 4;
	localparam int FRONT_STAGES   = 12;
	localparam int DIV_BITS       = 2;
	localparam int DIV_STAGES     = 64 / DIV_BITS;

	localparam logic [1:0] REG_TEMP_COEFFS = 2'd0;
	localparam logic [1:0] REG_PRESS_LOW   = 2'd1;
	localparam logic [1:0] REG_PRESS_HIGH  = 2'd2;
	localparam logic [1:0] REG_PRESS_NINE  = 2'd3;

	localparam int          FINE_OFFSET = 128000;
	localparam int          PRESS_FULL  = 1048576;
	localparam logic [11:0] NUM_SCALE   = 12'd3125;
	localparam int          DEN_BIAS_SH = 47;
	localparam int          DEN_SH      = 33;
	localparam int          P4_SH       = 35;
	localparam int          P5_SH       = 17;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
	} coeff_t;

	// Request handed from the front part to the back part.
	typedef struct packed {
		logic [18:0] temp;
		logic [23:0] fine;
		logic [63:0] num;
		logic [30:0] den;
		logic        inv;
	} work_t;

endpackage

// File: hdl/pressure_temperature_compensation.sv
// Throughput: one request per cycle unless the queue fills or a result is held;
// the 64-bit division retires two quotient bits per stage over 32 stages, and the
// widest multiplies are split into 32-bit halves.
// A four-entry queue between the front and back parts lets either side stall alone.
// Reset is asynchronous and active low; it empties the pipeline and the queue and
// clears all calibration registers to zero.
module pressure_temperature_compensation #(
	parameter int FIFO_DEPTH = ptc_pkg::FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// raw_temperature [19:0], raw_pressure [39:20]
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// temperature [18:0], fine_temperature [42:19], pressure [74:43], zero pad [79:75]
	output logic [79:0] m_axis_tdata,
	// pressure_invalid [0]
	output logic [0:0]  m_axis_tuser,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import ptc_pkg::*;

	coeff_t      coeff_q;
	logic        q_push, q_full, q_pop, q_valid;
	work_t       q_in, q_out;
	logic [18:0] temperature;
	logic [23:0] fine_temperature;
	logic [31:0] pressure;
	logic        pressure_invalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEMP_COEFFS: begin
					coeff_q.t1 <= cfg_data[15:0];
					coeff_q.t2 <= cfg_data[31:16];
					coeff_q.t3 <= cfg_data[47:32];
				end
				REG_PRESS_LOW: begin
					coeff_q.p1 <= cfg_data[15:0];
					coeff_q.p2 <= cfg_data[31:16];
					coeff_q.p3 <= cfg_data[47:32];
					coeff_q.p4 <= cfg_data[63:48];
				end
				REG_PRESS_HIGH: begin
					coeff_q.p5 <= cfg_data[15:0];
					coeff_q.p6 <= cfg_data[31:16];
					coeff_q.p7 <= cfg_data[47:32];
					coeff_q.p8 <= cfg_data[63:48];
				end
				REG_PRESS_NINE: begin
					coeff_q.p9 <= cfg_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	ptc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.coeff           (coeff_q),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.raw_temperature (s_axis_tdata[19:0]),
		.raw_pressure    (s_axis_tdata[39:20]),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_item          (q_in)
	);

	ptc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.din       (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.dout      (q_out)
	);

	ptc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.coeff            (coeff_q),
		.q_valid          (q_valid),
		.q_item           (q_out),
		.q_pop            (q_pop),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.temperature      (temperature),
		.fine_temperature (fine_temperature),
		.pressure         (pressure),
		.pressure_invalid (pressure_invalid)
	);

	assign m_axis_tdata = {5'd0, pressure, fine_temperature, temperature};
	assign m_axis_tuser = pressure_invalid;

endmodule

// File: hdl/ptc_front.sv
module ptc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  ptc_pkg::coeff_t coeff,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [19:0]     raw_temperature,
	input  logic [19:0]     raw_pressure,
	input  logic            q_full,
	output logic            q_push,
	output ptc_pkg::work_t  q_item
);
	import ptc_pkg::*;

	typedef struct packed {
		logic [18:0] temp;
		logic [23:0] fine;
		logic [20:0] pr;
	} pay_t;

	localparam logic [63:0] DEN_BIAS = 64'd1 << DEN_BIAS_SH;

	logic [FRONT_STAGES-1:0] v_q;
	logic                    en;

	logic signed [17:0] d1_s1;
	logic signed [16:0] d2_s1;
	logic [20:0]        pr_s1, pr_s2, pr_s3, pr_s4;
	logic signed [33:0] m1_s2, sq_s2;
	logic signed [22:0] at_s3;
	logic signed [38:0] m2_s3;
	logic signed [25:0] fine_s4;
	logic signed [28:0] t5;
	logic signed [26:0] a_s5;
	pay_t               pay_s5, pay_s6, pay_s7, pay_s8, pay_s9, pay_s10, pay_s11;
	logic signed [53:0] aa_s6;
	logic signed [42:0] ap5_s6, ap2_s6, ap5_s7, ap2_s7, ap5_s8, ap2_s8;
	logic signed [48:0] l6_s7, l3_s7;
	logic signed [38:0] h6_s7, h3_s7;
	logic [63:0]        aap6_s8, aap3_s8;
	logic [63:0]        b_s9, x_s9;
	logic [47:0]        xl_s10;
	logic [31:0]        xh_s10;
	logic [63:0]        n0_s10;
	logic [63:0]        dsum;
	logic [30:0]        den_s11;
	logic [43:0]        nl_s11;
	logic [31:0]        nh_s11;
	work_t              item_s12;

	// The whole front part advances together unless its last stage is blocked.
	assign en       = ~v_q[FRONT_STAGES-1] | ~q_full;
	assign in_ready = en;
	assign q_push   = v_q[FRONT_STAGES-1] & ~q_full;
	assign q_item   = item_s12;

	assign t5   = 29'(fine_s4) * 29'sd5 + 29'sd128;
	assign dsum = 64'(xl_s10) + {xh_s10, 32'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[FRONT_STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1 <= $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, coeff.t1, 1'b0});
			d2_s1 <= $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, coeff.t1});
			pr_s1 <= 21'(PRESS_FULL) - {1'b0, raw_pressure};

			m1_s2 <= d1_s1 * $signed(coeff.t2);
			sq_s2 <= d2_s1 * d2_s1;
			pr_s2 <= pr_s1;

			at_s3 <= 23'(m1_s2 >>> 11);
			m2_s3 <= $signed({1'b0, sq_s2[33:12]}) * $signed(coeff.t3);
			pr_s3 <= pr_s2;

			fine_s4 <= 26'(at_s3) + 26'(m2_s3 >>> 14);
			pr_s4   <= pr_s3;

			a_s5        <= 27'(fine_s4) - 27'(FINE_OFFSET);
			pay_s5.temp <= t5[26:8];
			pay_s5.fine <= fine_s4[23:0];
			pay_s5.pr   <= pr_s4;

			aa_s6  <= a_s5 * a_s5;
			ap5_s6 <= a_s5 * $signed(coeff.p5);
			ap2_s6 <= a_s5 * $signed(coeff.p2);
			pay_s6 <= pay_s5;

			// The squared term is split in halves so each product stays narrow.
			l6_s7  <= $signed({1'b0, aa_s6[31:0]}) * $signed(coeff.p6);
			h6_s7  <= $signed({1'b0, aa_s6[53:32]}) * $signed(coeff.p6);
			l3_s7  <= $signed({1'b0, aa_s6[31:0]}) * $signed(coeff.p3);
			h3_s7  <= $signed({1'b0, aa_s6[53:32]}) * $signed(coeff.p3);
			ap5_s7 <= ap5_s6;
			ap2_s7 <= ap2_s6;
			pay_s7 <= pay_s6;

			aap6_s8 <= 64'(l6_s7) + {h6_s7[31:0], 32'd0};
			aap3_s8 <= 64'(l3_s7) + {h3_s7[31:0], 32'd0};
			ap5_s8  <= ap5_s7;
			ap2_s8  <= ap2_s7;
			pay_s8  <= pay_s7;

			b_s9   <= aap6_s8 + (64'(ap5_s8) << P5_SH) + (64'($signed(coeff.p4)) << P4_SH);
			x_s9   <= DEN_BIAS + 64'($signed(aap3_s8) >>> 8) + (64'(ap2_s8) << 12);
			pay_s9 <= pay_s8;

			xl_s10  <= x_s9[31:0] * coeff.p1;
			xh_s10  <= 32'(x_s9[63:32] * coeff.p1);
			n0_s10  <= (64'(pay_s9.pr) << 31) - b_s9;
			pay_s10 <= pay_s9;

			den_s11 <= dsum[63:DEN_SH];
			nl_s11  <= n0_s10[31:0] * NUM_SCALE;
			nh_s11  <= 32'(n0_s10[63:32] * NUM_SCALE);
			pay_s11 <= pay_s10;

			item_s12.temp <= pay_s11.temp;
			item_s12.fine <= pay_s11.fine;
			item_s12.num  <= 64'(nl_s11) + {nh_s11, 32'd0};
			item_s12.den  <= den_s11;
			item_s12.inv  <= (den_s11 == '0);
		end
	end

endmodule

// File: hdl/ptc_fifo.sv
module ptc_fifo #(
	parameter int DEPTH = ptc_pkg::FIFO_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ptc_pkg::work_t din,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output ptc_pkg::work_t dout
);
	import ptc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	work_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push, do_pop;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push & ~full;
	assign do_pop    = pop & not_empty;
	assign dout      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: hdl/ptc_back.sv
module ptc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ptc_pkg::coeff_t coeff,
	input  logic            q_valid,
	input  ptc_pkg::work_t  q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [18:0]     temperature,
	output logic [23:0]     fine_temperature,
	output logic [31:0]     pressure,
	output logic            pressure_invalid
);
	import ptc_pkg::*;

	typedef struct packed {
		logic [18:0] temp;
		logic [23:0] fine;
		logic        inv;
	} hold_t;

	typedef struct packed {
		logic [30:0] r;
		logic [63:0] dq;
		logic [30:0] mb;
		logic        neg;
		hold_t       h;
	} div_t;

	localparam int NB = DIV_STAGES + 8;

	function automatic div_t div_step(div_t x);
		div_t        y;
		logic [31:0] t;
		logic        ge;
		y = x;
		for (int i = 0; i < DIV_BITS; i++) begin
			t    = {y.r, y.dq[63]};
			ge   = (t >= {1'b0, y.mb});
			y.dq = {y.dq[62:0], ge};
			y.r  = ge ? 31'(t - {1'b0, y.mb}) : t[30:0];
		end
		return y;
	endfunction

	logic [NB-1:0] bv_q;
	logic          en;
	div_t          ds [DIV_STAGES+1];

	hold_t              h_s33, h_s34, h_s35, h_s36, h_s37, h_s38;
	logic [63:0]        p_s33, p_s34, p_s35, p_s36, p_s37;
	logic signed [63:0] ps;
	logic [63:0]        ll_s34;
	logic [31:0]        lh_s34;
	logic signed [48:0] p8l_s34, ql_s36;
	logic [31:0]        p8h_s34, qh_s36;
	logic [63:0]        pp8, qq;
	logic [63:0]        sq_s35, b_s35, b_s36, b_s37, a_s37;
	logic [39:0]        sum_s38;
	logic [18:0]        temp_q;
	logic [23:0]        fine_q;
	logic [31:0]        press_q;
	logic               inv_q;

	// A held result stalls the whole back part; the queue absorbs the front.
	assign en        = ~bv_q[NB-1] | out_ready;
	assign q_pop     = en & q_valid;
	assign out_valid = bv_q[NB-1];

	assign temperature      = temp_q;
	assign fine_temperature = fine_q;
	assign pressure         = press_q;
	assign pressure_invalid = inv_q;

	assign ps  = $signed(p_s33) >>> 13;
	assign pp8 = 64'(p8l_s34) + {p8h_s34, 32'd0};
	assign qq  = 64'(ql_s36) + {qh_s36, 32'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_q <= '0;
		end else if (en) begin
			bv_q <= {bv_q[NB-2:0], q_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ds[0].r      <= '0;
			ds[0].dq     <= q_item.num[63] ? 64'd0 - q_item.num : q_item.num;
			ds[0].mb     <= q_item.den[30] ? 31'd0 - q_item.den : q_item.den;
			ds[0].neg    <= q_item.num[63] ^ q_item.den[30];
			ds[0].h.temp <= q_item.temp;
			ds[0].h.fine <= q_item.fine;
			ds[0].h.inv  <= q_item.inv;
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				ds[k+1] <= div_step(ds[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s33 <= ds[DIV_STAGES].neg ? 64'd0 - ds[DIV_STAGES].dq : ds[DIV_STAGES].dq;
			h_s33 <= ds[DIV_STAGES].h;

			// Squares and products are kept modulo 2^64 from 32-bit halves.
			ll_s34  <= ps[31:0] * ps[31:0];
			lh_s34  <= 32'(ps[31:0] * ps[63:32]);
			p8l_s34 <= $signed({1'b0, p_s33[31:0]}) * $signed(coeff.p8);
			p8h_s34 <= 32'($signed(p_s33[63:32]) * $signed(coeff.p8));
			p_s34   <= p_s33;
			h_s34   <= h_s33;

			sq_s35 <= ll_s34 + {lh_s34[30:0], 1'b0, 32'd0};
			b_s35  <= 64'($signed(pp8) >>> 19);
			p_s35  <= p_s34;
			h_s35  <= h_s34;

			ql_s36 <= $signed({1'b0, sq_s35[31:0]}) * $signed(coeff.p9);
			qh_s36 <= 32'($signed(sq_s35[63:32]) * $signed(coeff.p9));
			b_s36  <= b_s35;
			p_s36  <= p_s35;
			h_s36  <= h_s35;

			a_s37 <= 64'($signed(qq) >>> 25);
			b_s37 <= b_s36;
			p_s37 <= p_s36;
			h_s37 <= h_s36;

			sum_s38 <= 40'(p_s37 + a_s37 + b_s37);
			h_s38   <= h_s37;

			temp_q  <= h_s38.temp;
			fine_q  <= h_s38.fine;
			inv_q   <= h_s38.inv;
			press_q <= h_s38.inv ? '0 :
				sum_s38[39:8] + {{12{coeff.p7[15]}}, coeff.p7, 4'd0};
		end
	end

endmodule

// File: hdl/ptc_checker.sv
module ptc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [79:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	// No result may be shown while reset is applied.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

	// A forced result carries a pressure of zero.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[74:43] == 32'd0)
		else $error("pressure not zero on invalid result");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[79:75] == 5'd0)
		else $error("pad bits of result not zero");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ptc_pkg::*;

	typedef struct {
		logic [18:0] temp;
		logic [23:0] fine;
		logic [31:0] press;
		logic        inv;
	} reading_t;

	typedef struct {
		logic [19:0] raw_t;
		logic [19:0] raw_p;
	} raw_pair_t;

	localparam longint CYCLE_LIMIT = 2000000;
	localparam int     DRAIN_WAIT  = 80;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	// Shadow copies of the calibration registers.
	logic [47:0] temp_cal;
	logic [63:0] press_cal_low;
	logic [63:0] press_cal_high;
	logic [15:0] press_cal_nine;

	reading_t expected_readings[$];
	int       error_count;
	longint   cycle_count;
	bit       steady_mode;
	bit       hold_request;
	int       ready_stall;

	pressure_temperature_compensation dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic signed [63:0] sext16(input logic [15:0] v);
		logic signed [63:0] r;
		r = 64'($signed(v));
		return r;
	endfunction

	// Compensates one reading pair with the current shadow calibration.
	function automatic reading_t compensate(input logic [19:0] raw_t, input logic [19:0] raw_p);
		logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic signed [63:0] d, a, b, fine, tmp, den, p, num;
		reading_t r;
		t1 = {48'd0, temp_cal[15:0]};
		t2 = sext16(temp_cal[31:16]);
		t3 = sext16(temp_cal[47:32]);
		p1 = {48'd0, press_cal_low[15:0]};
		p2 = sext16(press_cal_low[31:16]);
		p3 = sext16(press_cal_low[47:32]);
		p4 = sext16(press_cal_low[63:48]);
		p5 = sext16(press_cal_high[15:0]);
		p6 = sext16(press_cal_high[31:16]);
		p7 = sext16(press_cal_high[47:32]);
		p8 = sext16(press_cal_high[63:48]);
		p9 = sext16(press_cal_nine);

		d = $signed({47'd0, raw_t[19:3]}) - (t1 <<< 1);
		a = (d * t2) >>> 11;
		d = $signed({48'd0, raw_t[19:4]}) - t1;
		b = (((d * d) >>> 12) * t3) >>> 14;
		fine = a + b;
		tmp = (fine * 64'sd5 + 64'sd128) >>> 8;

		a = fine - 64'sd128000;
		b = a * a * p6;
		b = b + ((a * p5) <<< 17);
		b = b + (p4 <<< 35);
		den = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
		den = (((64'sd1 <<< 47) + den) * p1) >>> 33;

		r.temp = tmp[18:0];
		r.fine = fine[23:0];
		r.press = '0;
		r.inv = 1'b0;
		if (den == 0) begin
			r.inv = 1'b1;
		end else begin
			p = 64'sd1048576 - $signed({44'd0, raw_p});
			num = ((p <<< 31) - b) * 64'sd3125;
			// The most negative numerator over minus one wraps back onto itself.
			if (num == {1'b1, 63'd0} && den == -64'sd1)
				p = num;
			else
				p = num / den;
			a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
			b = (p8 * p) >>> 19;
			p = ((p + a + b) >>> 8) + (p7 <<< 4);
			r.press = p[31:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (error_count < 30)
			$display("mismatch on %s at cycle %0d: got %h, expected %h",
				what, cycle_count, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		reading_t e;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_readings.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata[63:0], 64'd0);
			end else begin
				e = expected_readings.pop_front();
				if (m_axis_tdata[18:0] !== e.temp)
					report_mismatch("temperature", 64'(m_axis_tdata[18:0]), 64'(e.temp));
				if (m_axis_tdata[42:19] !== e.fine)
					report_mismatch("fine_temperature", 64'(m_axis_tdata[42:19]),
						64'(e.fine));
				if (m_axis_tdata[74:43] !== e.press)
					report_mismatch("pressure", 64'(m_axis_tdata[74:43]), 64'(e.press));
				if (m_axis_tuser[0] !== e.inv)
					report_mismatch("pressure_invalid", 64'(m_axis_tuser[0]), 64'(e.inv));
			end
		end
	end

	// Result side back-pressure, with one long hold-off on request.
	initial begin
		int r;
		ready_stall = 0;
		forever begin
			@(posedge clk);
			if (ready_stall > 0) begin
				ready_stall--;
				m_axis_tready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				ready_stall = 300;
				m_axis_tready <= 1'b0;
			end else if (steady_mode) begin
				m_axis_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					m_axis_tready <= 1'b1;
				end else if (r < 95) begin
					ready_stall = $urandom_range(0, 2);
					m_axis_tready <= 1'b0;
				end else begin
					ready_stall = $urandom_range(10, 40);
					m_axis_tready <= 1'b0;
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (steady_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// The write enable stays high across a burst of writes; the caller drops it.
	task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_TEMP_COEFFS: temp_cal = value[47:0];
			REG_PRESS_LOW:   press_cal_low = value;
			REG_PRESS_HIGH:  press_cal_high = value;
			REG_PRESS_NINE:  press_cal_nine = value[15:0];
			default: ;
		endcase
	endtask

	task automatic load_calibration(input logic [47:0] tc, input logic [63:0] pl,
			input logic [63:0] ph, input logic [15:0] p9);
		write_reg(REG_TEMP_COEFFS, {16'd0, tc});
		write_reg(REG_PRESS_LOW, pl);
		write_reg(REG_PRESS_HIGH, ph);
		write_reg(REG_PRESS_NINE, {48'd0, p9});
		cfg_we <= 1'b0;
	endtask

	// Offers one request; the expectation is either typed in or predicted.
	task automatic send_pair(input logic [19:0] raw_t, input logic [19:0] raw_p,
			input bit typed, input reading_t typed_result);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {raw_p, raw_t};
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (typed)
			expected_readings.push_back(typed_result);
		else
			expected_readings.push_back(compensate(raw_t, raw_p));
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	localparam logic [47:0] TC_TYPICAL = {16'hFC18, 16'h6743, 16'h6B70};
	localparam logic [63:0] PL_TYPICAL = {16'h0B27, 16'h0BD0, 16'hD643, 16'h8E7D};
	localparam logic [63:0] PH_TYPICAL = {16'hC6F8, 16'h3C8C, 16'hFFF9, 16'h008C};
	localparam logic [15:0] P9_TYPICAL = 16'h1770;

	initial begin
		raw_pair_t reset_rows[4];
		raw_pair_t typical_rows[12];
		reading_t  invalid_zero;
		reading_t  unused;
		logic [19:0] rt, rp;
		int n;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TEMP_COEFFS;
		cfg_data = '0;
		error_count = 0;
		cycle_count = 0;
		steady_mode = 1'b0;
		hold_request = 1'b0;
		temp_cal = '0;
		press_cal_low = '0;
		press_cal_high = '0;
		press_cal_nine = '0;
		unused = '{default: '0};

		// With every coefficient zero the temperature terms vanish and the
		// pressure denominator is zero.
		invalid_zero = '{temp: '0, fine: '0, press: '0, inv: 1'b1};
		reset_rows = '{'{20'h00000, 20'h00000}, '{20'hFFFFF, 20'hFFFFF},
			'{20'h00000, 20'hFFFFF}, '{20'hFFFFF, 20'h00000}};
		typical_rows = '{'{20'd519888, 20'd415148}, '{20'h00000, 20'h00000},
			'{20'hFFFFF, 20'hFFFFF}, '{20'h00000, 20'hFFFFF},
			'{20'hFFFFF, 20'h00000}, '{20'h80000, 20'h80000},
			'{20'h7FFFF, 20'h7FFFF}, '{20'd440000, 20'd300000},
			'{20'd600000, 20'd250000}, '{20'h00001, 20'h00001},
			'{20'hAAAAA, 20'h55555}, '{20'h55555, 20'hAAAAA}};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (reset_rows[i])
			send_pair(reset_rows[i].raw_t, reset_rows[i].raw_p, 1'b1, invalid_zero);
		drain();

		load_calibration(TC_TYPICAL, PL_TYPICAL, PH_TYPICAL, P9_TYPICAL);
		foreach (typical_rows[i])
			send_pair(typical_rows[i].raw_t, typical_rows[i].raw_p, 1'b0, unused);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: load_calibration(TC_TYPICAL, PL_TYPICAL, PH_TYPICAL, P9_TYPICAL);
				1: load_calibration('1, '1, '1, '1);
				2: load_calibration({16'h7FFF, 16'h7FFF, 16'hFFFF},
					{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
					{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h7FFF);
				3: load_calibration({16'h8000, 16'h8000, 16'h0000},
					{16'h8000, 16'h8000, 16'h8000, 16'h0001},
					{16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000);
				// P1 of zero forces every pressure to be flagged invalid.
				4: load_calibration(TC_TYPICAL, {PL_TYPICAL[63:16], 16'h0000},
					PH_TYPICAL, P9_TYPICAL);
				default: load_calibration(48'({$urandom, $urandom}),
					{$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom));
			endcase
			steady_mode = (ph == 5);
			if (ph == 2)
				hold_request = 1'b1;
			n = 110;
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 99) < 70) begin
					rt = 20'($urandom_range(380000, 620000));
					rp = 20'($urandom_range(200000, 480000));
				end else begin
					rt = 20'($urandom);
					rp = 20'($urandom);
				end
				send_pair(rt, rp, 1'b0, unused);
			end
			drain();
			steady_mode = 1'b0;
		end

		if (error_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
